### design/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared constants, character classes and step control for the duration
// text parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtp_pkg;

  localparam int SECONDS_WIDTH_DEF = 32;
  localparam int TOTAL_WIDTH       = 32;

  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int FIELD_MAX    = 59;
  localparam int FIELD_SAT    = 60;
  localparam int DIGIT_BASE   = 10;

  // Colon form phases: three per number (start, after sign, in digits),
  // then the two trailing-blank phases.
  localparam logic [3:0] CP_NUM0   = 4'd0;
  localparam logic [3:0] CP_SIGN0  = 4'd1;
  localparam logic [3:0] CP_DIG0   = 4'd2;
  localparam logic [3:0] CP_NUM1   = 4'd3;
  localparam logic [3:0] CP_SIGN1  = 4'd4;
  localparam logic [3:0] CP_DIG1   = 4'd5;
  localparam logic [3:0] CP_NUM2   = 4'd6;
  localparam logic [3:0] CP_SIGN2  = 4'd7;
  localparam logic [3:0] CP_DIG2   = 4'd8;
  localparam logic [3:0] CP_TRAIL3 = 4'd9;
  localparam logic [3:0] CP_TRAIL2 = 4'd10;

  // Unit form phases
  localparam logic [1:0] UP_START = 2'd0;
  localparam logic [1:0] UP_NUM   = 2'd1;
  localparam logic [1:0] UP_GAP   = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_M  = 8'h6d;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_Z  = 8'h7a;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic feed;    // byte goes into both trackers
    logic finish;  // last byte taken: snapshot and clear
  } dtp_step_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return d[3:0];
  endfunction

endpackage

### design/dtp_colon.sv
// ----------------------------------------------------------------------------
// dtp_colon
// Tracks the H:M:S / M:S form one byte at a time and offers the state after
// the current byte for the end-of-string snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtp_colon #(
  parameter int SECONDS_WIDTH = dtp_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dtp_pkg::dtp_step_t      step,
  input  logic [7:0]              char_byte,
  output logic [3:0]              phase_next,
  output logic [SECONDS_WIDTH:0]  first_next,
  output logic [6:0]              second_next,
  output logic [6:0]              third_next,
  output logic [2:0]              sign_next,
  output logic                    failed_next
);
  import dtp_pkg::*;

  localparam int AW = SECONDS_WIDTH + 5;
  localparam int FW = 10;
  localparam logic [AW-1:0] FIRST_CAP = AW'(1) << SECONDS_WIDTH;

  localparam logic [1:0] SUB_START  = 2'd0;
  localparam logic [1:0] SUB_SIGN   = 2'd1;
  localparam logic [1:0] SUB_DIGITS = 2'd2;
  localparam logic [1:0] SUB_TRAIL  = 2'd3;

  logic [3:0]             phase;
  logic [SECONDS_WIDTH:0] first;
  logic [6:0]             second;
  logic [6:0]             third;
  logic [2:0]             sign;
  logic                   failed;

  logic [1:0]             field;
  logic [1:0]             sub;
  logic [3:0]             dval;
  logic                   do_digit;
  logic [AW-1:0]          first_acc_w;
  logic [SECONDS_WIDTH:0] first_acc;
  logic [6:0]             field_sel;
  logic [FW-1:0]          field_acc_w;
  logic [6:0]             field_acc;

  always_comb begin
    unique case (phase)
      CP_NUM0:  begin field = 2'd0; sub = SUB_START;  end
      CP_SIGN0: begin field = 2'd0; sub = SUB_SIGN;   end
      CP_DIG0:  begin field = 2'd0; sub = SUB_DIGITS; end
      CP_NUM1:  begin field = 2'd1; sub = SUB_START;  end
      CP_SIGN1: begin field = 2'd1; sub = SUB_SIGN;   end
      CP_DIG1:  begin field = 2'd1; sub = SUB_DIGITS; end
      CP_NUM2:  begin field = 2'd2; sub = SUB_START;  end
      CP_SIGN2: begin field = 2'd2; sub = SUB_SIGN;   end
      CP_DIG2:  begin field = 2'd2; sub = SUB_DIGITS; end
      default:  begin field = 2'd0; sub = SUB_TRAIL;  end
    endcase
  end

  assign dval        = digit_val(char_byte);
  assign first_acc_w = AW'(first) * AW'(DIGIT_BASE) + AW'(dval);
  assign first_acc   = (first_acc_w > FIRST_CAP) ? FIRST_CAP[SECONDS_WIDTH:0]
                                                 : first_acc_w[SECONDS_WIDTH:0];
  assign field_sel   = (field == 2'd1) ? second : third;
  assign field_acc_w = FW'(field_sel) * FW'(DIGIT_BASE) + FW'(dval);
  assign field_acc   = (field_acc_w > FW'(FIELD_SAT)) ? 7'(FIELD_SAT) : field_acc_w[6:0];

  always_comb begin
    phase_next  = phase;
    first_next  = first;
    second_next = second;
    third_next  = third;
    sign_next   = sign;
    failed_next = failed;
    do_digit    = 1'b0;
    if (step.feed && !failed) begin
      unique case (sub)
        SUB_START: begin
          if (is_blank(char_byte)) begin
            phase_next = phase;
          end else if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
            if (char_byte == CH_MINUS) begin
              sign_next = sign | (3'(1) << field);
            end
            phase_next = phase + 4'd1;
          end else if (is_digit(char_byte)) begin
            do_digit   = 1'b1;
            phase_next = phase + 4'd2;
          end else begin
            failed_next = 1'b1;
          end
        end
        SUB_SIGN: begin
          if (is_digit(char_byte)) begin
            do_digit   = 1'b1;
            phase_next = phase + 4'd1;
          end else begin
            failed_next = 1'b1;
          end
        end
        SUB_DIGITS: begin
          if (is_digit(char_byte)) begin
            do_digit = 1'b1;
          end else if (char_byte == CH_COLON && field != 2'd2) begin
            phase_next = phase + 4'd1;
          end else if (is_blank(char_byte) && field != 2'd0) begin
            phase_next = (field == 2'd1) ? CP_TRAIL2 : CP_TRAIL3;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: begin
          if (!is_blank(char_byte)) begin
            failed_next = 1'b1;
          end
        end
      endcase
    end
    if (do_digit) begin
      case (field)
        2'd0:    first_next  = first_acc;
        2'd1:    second_next = field_acc;
        default: third_next  = field_acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || step.finish) begin
      phase  <= CP_NUM0;
      first  <= '0;
      second <= '0;
      third  <= '0;
      sign   <= '0;
      failed <= 1'b0;
    end else begin
      phase  <= phase_next;
      first  <= first_next;
      second <= second_next;
      third  <= third_next;
      sign   <= sign_next;
      failed <= failed_next;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_finish: assert property (@(posedge clk) disable iff (rst)
    step.finish |=> (phase == CP_NUM0 && !failed && sign == 3'd0))
    else $error("colon tracker not cleared after last beat");

  a_fields_saturate: assert property (@(posedge clk) disable iff (rst)
    (second <= 7'(FIELD_SAT)) && (third <= 7'(FIELD_SAT)))
    else $error("minute/second field beyond saturation");
`endif

endmodule

### design/dtp_unit.sv
// ----------------------------------------------------------------------------
// dtp_unit
// Tracks the unit form (digit runs with optional h/m/s) and keeps a
// saturating running total in seconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtp_unit #(
  parameter int SECONDS_WIDTH = dtp_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dtp_pkg::dtp_step_t      step,
  input  logic [7:0]              char_byte,
  output logic [1:0]              phase_next,
  output logic [SECONDS_WIDTH:0]  number_next,
  output logic [SECONDS_WIDTH:0]  total_next,
  output logic                    failed_next
);
  import dtp_pkg::*;

  localparam int AW = SECONDS_WIDTH + 5;
  localparam int TW = SECONDS_WIDTH + 14;
  localparam logic [AW-1:0] NUM_CAP   = AW'(1) << SECONDS_WIDTH;
  localparam logic [TW-1:0] TOTAL_CAP = TW'(1) << SECONDS_WIDTH;
  localparam logic [11:0]   MULT_H    = 12'(SEC_PER_HOUR);
  localparam logic [11:0]   MULT_M    = 12'(SEC_PER_MIN);
  localparam logic [11:0]   MULT_S    = 12'd1;

  logic [1:0]             phase;
  logic [SECONDS_WIDTH:0] number;
  logic [SECONDS_WIDTH:0] total;
  logic                   failed;

  logic [7:0]             lc;
  logic [AW-1:0]          num_acc_w;
  logic [SECONDS_WIDTH:0] num_acc;
  logic                   do_add;
  logic [11:0]            mult;
  logic [TW-1:0]          add_w;
  logic [SECONDS_WIDTH:0] total_add;

  assign lc        = char_byte | CASE_BIT;
  assign num_acc_w = AW'(number) * AW'(DIGIT_BASE) + AW'(digit_val(char_byte));
  assign num_acc   = (num_acc_w > NUM_CAP) ? NUM_CAP[SECONDS_WIDTH:0]
                                           : num_acc_w[SECONDS_WIDTH:0];
  assign add_w     = TW'(total) + TW'(number) * TW'(mult);
  assign total_add = (add_w > TOTAL_CAP) ? TOTAL_CAP[SECONDS_WIDTH:0]
                                         : add_w[SECONDS_WIDTH:0];

  always_comb begin
    phase_next  = phase;
    number_next = number;
    total_next  = total;
    failed_next = failed;
    do_add      = 1'b0;
    mult        = MULT_S;
    if (step.feed && !failed) begin
      unique case (phase)
        UP_NUM: begin
          if (is_digit(char_byte)) begin
            number_next = num_acc;
          end else if (is_alpha(char_byte)) begin
            phase_next = UP_GAP;
            if (lc == CH_LC_H) begin
              do_add = 1'b1;
              mult   = MULT_H;
            end else if (lc == CH_LC_M) begin
              do_add = 1'b1;
              mult   = MULT_M;
            end else if (lc == CH_LC_S) begin
              do_add = 1'b1;
            end else begin
              failed_next = 1'b1;
            end
          end else if (is_blank(char_byte) || char_byte == CH_COMMA) begin
            do_add     = 1'b1;
            phase_next = UP_GAP;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: begin
          if (is_blank(char_byte) || (char_byte == CH_COMMA && phase == UP_GAP)) begin
            phase_next = phase;
          end else if (is_digit(char_byte)) begin
            number_next = (SECONDS_WIDTH + 1)'(digit_val(char_byte));
            phase_next  = UP_NUM;
          end else begin
            failed_next = 1'b1;
          end
        end
      endcase
    end
    if (do_add) begin
      total_next  = total_add;
      number_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || step.finish) begin
      phase  <= UP_START;
      number <= '0;
      total  <= '0;
      failed <= 1'b0;
    end else begin
      phase  <= phase_next;
      number <= number_next;
      total  <= total_next;
      failed <= failed_next;
    end
  end

`ifndef SYNTHESIS
  a_values_saturate: assert property (@(posedge clk) disable iff (rst)
    (number <= NUM_CAP[SECONDS_WIDTH:0]) && (total <= NUM_CAP[SECONDS_WIDTH:0]))
    else $error("unit number or total beyond saturation limit");
`endif

endmodule

### design/dtp_final.sv
// ----------------------------------------------------------------------------
// dtp_final
// Holds the end-of-string snapshot of both trackers, picks the colon form
// over the unit form, range-checks the total and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtp_final #(
  parameter int SECONDS_WIDTH = dtp_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dtp_pkg::dtp_step_t                  step,
  input  logic [3:0]                          colon_phase,
  input  logic [SECONDS_WIDTH:0]              colon_first,
  input  logic [6:0]                          colon_second,
  input  logic [6:0]                          colon_third,
  input  logic [2:0]                          colon_sign,
  input  logic                                colon_failed,
  input  logic [1:0]                          unit_phase,
  input  logic [SECONDS_WIDTH:0]              unit_number,
  input  logic [SECONDS_WIDTH:0]              unit_total,
  input  logic                                unit_failed,
  output logic                                snap_ready,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                parse_ok,
  output logic [dtp_pkg::TOTAL_WIDTH-1:0]     total_seconds
);
  import dtp_pkg::*;

  localparam int TW = (SECONDS_WIDTH + 14 > TOTAL_WIDTH) ? SECONDS_WIDTH + 14 : TOTAL_WIDTH;
  localparam int UW = SECONDS_WIDTH + 2;
  localparam logic [UW-1:0] UNIT_CAP = UW'(1) << SECONDS_WIDTH;

  logic                   snap_valid;
  logic [3:0]             cp;
  logic [SECONDS_WIDTH:0] ch;
  logic [6:0]             cm;
  logic [6:0]             cs;
  logic [2:0]             csg;
  logic                   cf;
  logic [1:0]             up;
  logic [SECONDS_WIDTH:0] un;
  logic [SECONDS_WIDTH:0] ut;
  logic                   uf;

  logic                   res_ready;
  logic                   nf2;
  logic                   nf3;
  logic                   neg;
  logic                   colon3;
  logic                   colon2;
  logic                   unit_have;
  logic [UW-1:0]          unit_sum;
  logic [SECONDS_WIDTH:0] unit_fin;
  logic [TW-1:0]          colon3_total;
  logic [TW-1:0]          colon2_total;
  logic [TW-1:0]          total;
  logic                   ok;

  assign res_ready  = !result_valid || !result_stall;
  assign snap_ready = !snap_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (step.finish) begin
      snap_valid <= 1'b1;
    end else if (res_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.finish) begin
      cp  <= colon_phase;
      ch  <= colon_first;
      cm  <= colon_second;
      cs  <= colon_third;
      csg <= colon_sign;
      cf  <= colon_failed;
      up  <= unit_phase;
      un  <= unit_number;
      ut  <= unit_total;
      uf  <= unit_failed;
    end
  end

  assign nf2 = (cp == CP_DIG1) || (cp == CP_TRAIL2);
  assign nf3 = (cp == CP_DIG2) || (cp == CP_TRAIL3);
  // a minus sign only matters on a nonzero value
  assign neg = (csg[0] && ch != '0) || (csg[1] && cm != '0) || (csg[2] && cs != '0);

  assign colon3 = !cf && nf3 && !neg && (cm <= 7'(FIELD_MAX)) && (cs <= 7'(FIELD_MAX));
  assign colon2 = !cf && nf2 && !neg && (cm <= 7'(FIELD_MAX));

  assign colon3_total = TW'(ch) * TW'(SEC_PER_HOUR) + TW'(cm) * TW'(SEC_PER_MIN) + TW'(cs);
  assign colon2_total = TW'(ch) * TW'(SEC_PER_MIN) + TW'(cm);

  // a digit run still open at the end counts as seconds
  assign unit_have = !uf && (up != UP_START);
  assign unit_sum  = UW'(ut) + UW'(un);
  assign unit_fin  = (up != UP_NUM)       ? ut :
                     (unit_sum > UNIT_CAP) ? UNIT_CAP[SECONDS_WIDTH:0] :
                                             unit_sum[SECONDS_WIDTH:0];

  always_comb begin
    if (colon3) begin
      total = colon3_total;
    end else if (colon2) begin
      total = colon2_total;
    end else if (unit_have) begin
      total = TW'(unit_fin);
    end else begin
      total = '0;
    end
  end

  assign ok = (total != '0) && (total[TW-1:SECONDS_WIDTH] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && snap_valid) begin
      parse_ok      <= ok;
      total_seconds <= ok ? total[TOTAL_WIDTH-1:0] : '0;
    end
  end

`ifndef SYNTHESIS
  a_fail_zero_total: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !parse_ok) |-> (total_seconds == '0))
    else $error("rejected string carries a nonzero total");
`endif

endmodule

### design/duration_text_parser.sv
// ----------------------------------------------------------------------------
// duration_text_parser
// Takes a duration string one byte a beat and, on the byte marked last, gives
// one beat with a valid flag and the total in seconds. The colon form
// (H:M:S or M:S) and the unit form (runs such as 1h 30m 5s) are followed side
// by side, the colon form winning when both fit. One byte is taken every
// cycle unless the last byte is held back: each byte passes through an input
// register and updates both form trackers in the following cycle, and bytes
// before the last never wait on the result side. The tracker state after the
// last byte is copied into a snapshot register and from there into the result
// register; the last byte is held back only while the snapshot register is
// still occupied by a previous string. A zero byte ends the text early;
// everything up to the marked last byte is then ignored. Totals of zero or
// at or above 2^SECONDS_WIDTH are reported as failed with a zero total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module duration_text_parser #(
  parameter int SECONDS_WIDTH = dtp_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  logic [7:0]                      char_byte,
  input  logic                            last_byte,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            parse_ok,
  output logic [dtp_pkg::TOTAL_WIDTH-1:0] total_seconds
);
  import dtp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       text_ended;
  logic       go;
  logic       snap_ready;
  dtp_step_t  step;

  logic [3:0]             c_phase;
  logic [SECONDS_WIDTH:0] c_first;
  logic [6:0]             c_second;
  logic [6:0]             c_third;
  logic [2:0]             c_sign;
  logic                   c_failed;
  logic [1:0]             u_phase;
  logic [SECONDS_WIDTH:0] u_number;
  logic [SECONDS_WIDTH:0] u_total;
  logic                   u_failed;

  // only the last byte needs room downstream
  assign go          = in_valid && (!in_last || snap_ready);
  assign char_stall  = in_valid && !go;
  assign step.feed   = go && !text_ended && (in_byte != CH_NUL);
  assign step.finish = go && in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!char_stall) begin
      in_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_byte <= char_byte;
      in_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || step.finish) begin
      text_ended <= 1'b0;
    end else if (go && in_byte == CH_NUL) begin
      text_ended <= 1'b1;
    end
  end

  dtp_colon #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_colon (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_byte   (in_byte),
    .phase_next  (c_phase),
    .first_next  (c_first),
    .second_next (c_second),
    .third_next  (c_third),
    .sign_next   (c_sign),
    .failed_next (c_failed)
  );

  dtp_unit #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_unit (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_byte   (in_byte),
    .phase_next  (u_phase),
    .number_next (u_number),
    .total_next  (u_total),
    .failed_next (u_failed)
  );

  dtp_final #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_final (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .colon_phase   (c_phase),
    .colon_first   (c_first),
    .colon_second  (c_second),
    .colon_third   (c_third),
    .colon_sign    (c_sign),
    .colon_failed  (c_failed),
    .unit_phase    (u_phase),
    .unit_number   (u_number),
    .unit_total    (u_total),
    .unit_failed   (u_failed),
    .snap_ready    (snap_ready),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .parse_ok      (parse_ok),
    .total_seconds (total_seconds)
  );

`ifndef SYNTHESIS
  a_body_never_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_last) |-> !char_stall)
    else $error("non-final byte held back");

  a_finish_clears_end: assert property (@(posedge clk) disable iff (rst)
    step.finish |=> !text_ended)
    else $error("end-of-text flag survived last beat");
`endif

endmodule
